/* sv/clti_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clti_pkg: shared types and constants of the core-local timer interruptor
// Address map, item kind codes, the decode word passed from the decoder to
// the datapath, and byte-lane helpers.
// ----------------------------------------------------------------------------
package clti_pkg;

    // Item kind codes
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Fixed hart count: one soft bit and one compare register
    localparam int HARTS = 1;

    // Region bases and sizes in bytes
    localparam logic [16:0] SOFT_BASE = 17'h0_0000;
    localparam logic [16:0] SOFT_SIZE = 17'(4 * HARTS);
    localparam logic [16:0] CMP_BASE  = 17'h0_4000;
    localparam logic [16:0] CMP_SIZE  = 17'(8 * HARTS);
    localparam logic [16:0] TIME_BASE = 17'h0_bff8;
    localparam logic [16:0] TIME_SIZE = 17'd8;

    // Decoded view of one word
    typedef struct packed {
        logic       is_tick;
        logic       is_rd;
        logic       is_wr;
        logic       sel_soft;
        logic       sel_cmp;
        logic       sel_time;
        logic       ok;
        logic [2:0] lane;
        logic [7:0] bytes_low;
        logic [7:0] byte_en;
    } clti_dec_t;

    // Expand a byte enable into a bit mask
    function automatic logic [63:0] expand_bytes(input logic [7:0] be);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[i*8 +: 8] = {8{be[i]}};
        end
        return m;
    endfunction

endpackage
`default_nettype wire

/* sv/clti_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clti_in_if: request channel
// Carries one tick, read or write word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface clti_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [3:0]  access_bytes;
    logic [63:0] write_value;
    logic [63:0] tick_amount;

    modport source (
        output valid, kind, offset, access_bytes, write_value, tick_amount,
        input  ready
    );
    modport sink (
        input  valid, kind, offset, access_bytes, write_value, tick_amount,
        output ready
    );
endinterface
`default_nettype wire

/* sv/clti_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clti_out_if: response channel
// Carries read data, access status and the two interrupt levels.
// ----------------------------------------------------------------------------
interface clti_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_value;
    logic        access_ok;
    logic        soft_irq;
    logic        timer_irq;

    modport source (
        output valid, read_value, access_ok, soft_irq, timer_irq,
        input  ready
    );
    modport sink (
        input  valid, read_value, access_ok, soft_irq, timer_irq,
        output ready
    );
endinterface
`default_nettype wire

/* sv/clti_decode.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clti_decode: address and width decoder
// Classifies a word, checks that every touched byte lies inside one region
// and produces the byte-lane enables.
// ----------------------------------------------------------------------------
module clti_decode (
    input  wire logic [1:0]         kind,
    input  wire logic [15:0]        offset,
    input  wire logic [3:0]         access_bytes,
    output clti_pkg::clti_dec_t     dec
);
    import clti_pkg::*;

    logic        nb_ok;
    logic        access;
    logic [16:0] start_addr;
    logic [16:0] end_addr;
    logic        in_soft;
    logic        in_cmp;
    logic        in_time;
    logic [8:0]  low_wide;

    // Check width and region bounds
    always_comb
    begin
        nb_ok      = (access_bytes >= 4'd1) && (access_bytes <= 4'd8);
        start_addr = {1'b0, offset};
        end_addr   = start_addr + {13'd0, access_bytes};
        access     = ((kind == KIND_READ) || (kind == KIND_WRITE)) && nb_ok;
        // Soft region starts at the window base, so only the end is checked
        in_soft    = end_addr <= (SOFT_BASE + SOFT_SIZE);
        in_cmp     = (start_addr >= CMP_BASE) && (end_addr <= (CMP_BASE + CMP_SIZE));
        in_time    = (start_addr >= TIME_BASE) && (end_addr <= (TIME_BASE + TIME_SIZE));
        low_wide   = (9'd1 << access_bytes) - 9'd1;
    end

    // Assemble decode word
    always_comb
    begin
        dec.is_tick   = (kind == KIND_TICK);
        dec.is_rd     = (kind == KIND_READ);
        dec.is_wr     = (kind == KIND_WRITE);
        dec.sel_soft  = access && in_soft;
        dec.sel_cmp   = access && !in_soft && in_cmp;
        dec.sel_time  = access && !in_soft && !in_cmp && in_time;
        dec.ok        = dec.is_tick || dec.sel_soft || dec.sel_cmp || dec.sel_time;
        dec.lane      = offset[2:0];
        dec.bytes_low = low_wide[7:0];
        dec.byte_en   = low_wide[7:0] << offset[2:0];
    end

endmodule
`default_nettype wire

/* sv/core_local_timer_interruptor_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// core_local_timer_interruptor_core: single-hart timer and software interrupt
// Keeps the 64-bit time counter, the compare value and the soft bit.
// ----------------------------------------------------------------------------
// Each request word (tick, read or write) is captured in an input register.
// It advances once the output register is empty or its response is taken;
// it is then decoded and applied to the timer state, and its response lands
// in an output register. One word is taken every cycle while the response
// side keeps up. The cycle of work holds the decode, the byte-lane merge and
// the 64-bit tick add; timer_irq is the time >= compare check taken straight
// from the state registers, which stay put while a response waits. Soft bit
// sits at offset 0x0-0x3, compare at 0x4000-0x4007, time at 0xbff8-0xbfff;
// accesses of 1 to 8 bytes use little-endian byte lanes, and a miss answers
// access_ok 0 with read data 0. A soft-bit store sets the bit when the full
// 64-bit data is nonzero.
// ----------------------------------------------------------------------------
module core_local_timer_interruptor_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    clti_in_if.sink     req,
    clti_out_if.source  rsp
);
    import clti_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] offset_reg;
    logic [3:0]  bytes_reg;
    logic [63:0] wvalue_reg;
    logic [63:0] tick_reg;

    // Timer state
    logic [63:0] time_reg;
    logic [63:0] time_next;
    logic [63:0] cmp_reg;
    logic [63:0] cmp_next;
    logic        soft_reg;
    logic        soft_next;

    // Output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] rdata_reg;
    logic [63:0] rdata_next;
    logic        ok_reg;

    clti_dec_t   dec;
    logic        advance;
    logic        accept;
    logic [5:0]  shamt;
    logic [63:0] src;
    logic [63:0] wmask;
    logic [63:0] merged;

    clti_decode u_decode (
        .kind         (kind_reg),
        .offset       (offset_reg),
        .access_bytes (bytes_reg),
        .dec          (dec)
    );

    // Handshake control
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || rsp.ready);
        req.ready      = !in_valid_reg || advance;
        accept         = req.valid && req.ready;
        in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : ((rsp.ready) ? 1'b0 : out_valid_reg);
    end

    // Byte-lane merge and extract
    always_comb
    begin
        shamt  = {dec.lane, 3'b000};
        src    = dec.sel_cmp ? cmp_reg : time_reg;
        wmask  = expand_bytes(dec.byte_en);
        merged = (src & ~wmask) | ((wvalue_reg << shamt) & wmask);
    end

    // Next state and response
    always_comb
    begin
        time_next  = time_reg;
        cmp_next   = cmp_reg;
        soft_next  = soft_reg;
        rdata_next = 64'd0;
        if (dec.is_tick)
        begin
            time_next = time_reg + tick_reg;
        end
        else if (dec.is_wr)
        begin
            if (dec.sel_soft)
            begin
                soft_next = (wvalue_reg != 64'd0);
            end
            if (dec.sel_cmp)
            begin
                cmp_next = merged;
            end
            if (dec.sel_time)
            begin
                time_next = merged;
            end
        end
        else if (dec.is_rd)
        begin
            if (dec.sel_soft)
            begin
                rdata_next = {63'd0, soft_reg};
            end
            else if (dec.sel_cmp || dec.sel_time)
            begin
                rdata_next = (src >> shamt) & expand_bytes(dec.bytes_low);
            end
        end
    end

    // Hold control and timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            time_reg      <= 64'd0;
            cmp_reg       <= 64'd0;
            soft_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                time_reg <= time_next;
                cmp_reg  <= cmp_next;
                soft_reg <= soft_next;
            end
        end
    end

    // Capture request and response words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= req.kind;
            offset_reg <= req.offset;
            bytes_reg  <= req.access_bytes;
            wvalue_reg <= req.write_value;
            tick_reg   <= req.tick_amount;
        end
        if (advance)
        begin
            rdata_reg <= rdata_next;
            ok_reg    <= dec.ok;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = rdata_reg;
    assign rsp.access_ok  = ok_reg;
    assign rsp.soft_irq   = soft_reg;
    assign rsp.timer_irq  = (time_reg >= cmp_reg);

    // Timer level in a fresh response matches the state it left behind
    a_timer_level: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (rsp.timer_irq == (time_reg >= cmp_reg)))
        else $error("timer_irq does not match time and compare");

    // A miss leaves all timer state untouched
    a_miss_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !dec.ok) |=> ($stable(time_reg) && $stable(cmp_reg) && $stable(soft_reg)))
        else $error("state changed on a missed access");

    // Only reads return data
    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !dec.is_rd) |=> (rsp.read_value == 64'd0))
        else $error("nonzero read data on a non-read word");

    // A response held back keeps its slot until taken
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !advance)
        else $error("response overwritten while stalled");

endmodule
`default_nettype wire
